[sv/sptf_pkg.sv]
// Package for the sensor pose frame transform: payload structs, register
// indexes, reset values, fixed-point constants and saturation helpers.
// No dependencies.
package sptf_pkg;

  localparam int POS_W   = 24;  // Q12.12 positions and offsets
  localparam int QC_W    = 16;  // Q2.14 quaternion components
  localparam int SCALE_W = 16;  // Q4.12 scale
  localparam int CFG_W   = 64;  // widest register
  localparam int IDX_W   = 3;

  localparam int POS_FRAC = 12;
  localparam int Q_FRAC   = 14;
  localparam int M_FRAC   = 28;

  // register indexes
  localparam logic [IDX_W-1:0] REG_FRAME_ROT = 3'd0;
  localparam logic [IDX_W-1:0] REG_LOCAL_ROT = 3'd1;
  localparam logic [IDX_W-1:0] REG_SCALE     = 3'd2;
  localparam logic [IDX_W-1:0] REG_OFFSET_X  = 3'd3;
  localparam logic [IDX_W-1:0] REG_OFFSET_Y  = 3'd4;
  localparam logic [IDX_W-1:0] REG_OFFSET_Z  = 3'd5;

  // reset values: identity rotations, unit scale, zero offset
  localparam logic [CFG_W-1:0]   QUAT_IDENTITY = 64'h4000_0000_0000_0000;
  localparam logic [SCALE_W-1:0] SCALE_ONE     = 16'h1000;

  typedef struct packed {
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    logic signed [QC_W-1:0]  ori_w;
    logic signed [QC_W-1:0]  ori_x;
    logic signed [QC_W-1:0]  ori_y;
    logic signed [QC_W-1:0]  ori_z;
  } sample_t;

  typedef struct packed {
    logic signed [POS_W-1:0] world_x;
    logic signed [POS_W-1:0] world_y;
    logic signed [POS_W-1:0] world_z;
    logic signed [QC_W-1:0]  world_ori_w;
    logic signed [QC_W-1:0]  world_ori_x;
    logic signed [QC_W-1:0]  world_ori_y;
    logic signed [QC_W-1:0]  world_ori_z;
  } result_t;

  function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [36:0] v);
    logic signed [POS_W-1:0] r;
    if (v > 37'sd8388607) begin
      r = 24'sd8388607;
    end else if (v < -37'sd8388608) begin
      r = -24'sd8388608;
    end else begin
      r = v[POS_W-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [QC_W-1:0] sat_ori(input logic signed [25:0] v);
    logic signed [QC_W-1:0] r;
    if (v > 26'sd32767) begin
      r = 16'sd32767;
    end else if (v < -26'sd32768) begin
      r = -16'sd32768;
    end else begin
      r = v[QC_W-1:0];
    end
    return r;
  endfunction

endpackage

[sv/sptf_quat_mul.sv]
// Two-stage pipelined Hamilton product of two Q.14 quaternions, rounded
// to Q.14 without saturation. Depends on sptf_pkg for Q_FRAC.
module sptf_quat_mul import sptf_pkg::*; #(
  parameter int AW = 16,
  parameter int BW = 16,
  parameter int RW = 20
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_vld,
  input  logic [3:0][AW-1:0]  a,
  input  logic [3:0][BW-1:0]  b,
  output logic                out_vld,
  output logic [3:0][RW-1:0]  r
);

  localparam int PW = AW + BW;
  localparam int SW = PW + 2;
  localparam logic signed [SW-1:0] HALF = SW'(1) <<< (Q_FRAC - 1);

  logic signed [PW-1:0] p [4][4];
  logic                 vld1;
  logic signed [SW-1:0] sw, sx, sy, sz;
  logic signed [SW-1:0] rw, rx, ry, rz;

  // stage 1: all sixteen partial products
  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        p[i][j] <= PW'($signed(a[i])) * PW'($signed(b[j]));
      end
    end
  end

  always_comb begin
    sw = SW'(p[0][0]) - SW'(p[1][1]) - SW'(p[2][2]) - SW'(p[3][3]);
    sx = SW'(p[0][1]) + SW'(p[1][0]) + SW'(p[2][3]) - SW'(p[3][2]);
    sy = SW'(p[0][2]) - SW'(p[1][3]) + SW'(p[2][0]) + SW'(p[3][1]);
    sz = SW'(p[0][3]) + SW'(p[1][2]) - SW'(p[2][1]) + SW'(p[3][0]);
    rw = (sw + HALF) >>> Q_FRAC;
    rx = (sx + HALF) >>> Q_FRAC;
    ry = (sy + HALF) >>> Q_FRAC;
    rz = (sz + HALF) >>> Q_FRAC;
  end

  // stage 2: sum, round half up
  always_ff @(posedge clk) begin
    r[0] <= rw[RW-1:0];
    r[1] <= rx[RW-1:0];
    r[2] <= ry[RW-1:0];
    r[3] <= rz[RW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1    <= 1'b0;
      out_vld <= 1'b0;
    end else begin
      vld1    <= in_vld;
      out_vld <= vld1;
    end
  end

`ifndef SYNTHESIS
  // rounded sums must fit the result width, else a component is truncated
  a_fits: assert property (@(posedge clk) disable iff (rst)
    vld1 |-> ((rw[SW-1:RW-1] == '0) || (rw[SW-1:RW-1] == '1))
          && ((rx[SW-1:RW-1] == '0) || (rx[SW-1:RW-1] == '1))
          && ((ry[SW-1:RW-1] == '0) || (ry[SW-1:RW-1] == '1))
          && ((rz[SW-1:RW-1] == '0) || (rz[SW-1:RW-1] == '1)))
    else $error("quaternion product overflows result width");
`endif

endmodule

[sv/sensor_pose_frame_transform.sv]
// Top level of the sensor pose frame transform: config registers, the
// position datapath and three chained quaternion multipliers.
// Depends on sptf_pkg and sptf_quat_mul.
//
// Usage:
//   Input channel: drive sample and raise start; the transaction is taken
//   at a rising edge with start high and busy low. busy is high while rst
//   is applied and for the first cycle after it; otherwise one transaction
//   may enter on every clock.
//   Output channel: done is high for exactly one cycle with the result on
//   the result port; the receiver cannot stall it, so capture it then.
//   Config: write frame_rotation, local_rotation, frame_scale and the
//   offsets through wr_en/wr_idx/wr_data while no transaction is in flight.
//   Unknown indexes are dropped.
//   Throughput: one transaction per cycle while busy is low. Six register
//   stages on position: the scale multiply, matrix build, matrix-vector
//   multiply, sum and round, offset and saturate, and a hold to meet
//   orientation; orientation runs three two-stage Hamilton products.
//   Reset: synchronous rst clears all valid bits (in-flight transactions
//   are dropped) and restores identity rotations, unit scale, zero offset.
module sensor_pose_frame_transform import sptf_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  sample_t          sample,
  output logic             done,
  output result_t          result,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_idx,
  input  logic [CFG_W-1:0] wr_data
);

  localparam int S_W = 28;   // scaled position
  localparam int M_W = 34;   // matrix entry at Q.28
  localparam int P_W = S_W + M_W;
  localparam int A_W = 64;
  localparam int R_W = A_W - M_FRAC;
  localparam logic signed [M_W-1:0] ONE_M  = M_W'(1) <<< M_FRAC;
  localparam logic signed [39:0]    HALF_S = 40'sd1 <<< (POS_FRAC - 1);
  localparam logic signed [A_W-1:0] HALF_M = A_W'(1) <<< (M_FRAC - 1);

  // configuration registers
  logic [CFG_W-1:0]        frame_rot;
  logic [CFG_W-1:0]        local_rot;
  logic signed [SCALE_W-1:0] frame_scale;
  logic signed [POS_W-1:0] off [3];

  logic accept;
  logic v1, v2, v3, v4, v5, v6;

  logic signed [QC_W-1:0] fw, fx, fy, fz;
  logic signed [POS_W-1:0] pos_in [3];
  logic signed [39:0]      sprod [3];

  logic signed [S_W-1:0] s1 [3];
  logic signed [S_W-1:0] s2 [3];
  logic signed [31:0] xx, yy, zz, xy, wz, xz, wy, yz, wx;
  logic signed [M_W-1:0] m [3][3];
  logic signed [P_W-1:0] mp [3][3];
  logic signed [A_W-1:0] acc [3];
  logic signed [R_W-1:0] rnd4 [3];
  logic signed [POS_W-1:0] pos5 [3];
  logic signed [POS_W-1:0] pos6 [3];

  logic [3:0][QC_W-1:0] fq, lq, oq;
  logic [3:0][16:0]     cq;
  logic [3:0][19:0]     t1;
  logic [3:0][22:0]     t2;
  logic [3:0][25:0]     t3;
  logic q1_vld, q2_vld, q3_vld;

  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    busy <= rst;
  end

  // config write port; drop unknown indexes
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_rot   <= QUAT_IDENTITY;
      local_rot   <= QUAT_IDENTITY;
      frame_scale <= SCALE_ONE;
      off[0]      <= '0;
      off[1]      <= '0;
      off[2]      <= '0;
    end else if (wr_en) begin
      case (wr_idx)
        REG_FRAME_ROT: frame_rot   <= wr_data;
        REG_LOCAL_ROT: local_rot   <= wr_data;
        REG_SCALE:     frame_scale <= wr_data[SCALE_W-1:0];
        REG_OFFSET_X:  off[0]      <= wr_data[POS_W-1:0];
        REG_OFFSET_Y:  off[1]      <= wr_data[POS_W-1:0];
        REG_OFFSET_Z:  off[2]      <= wr_data[POS_W-1:0];
        default: ;
      endcase
    end
  end

  // valid bits travel alongside the position stages
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else begin
      v1 <= accept;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
    end
  end

  assign fw = frame_rot[63:48];
  assign fx = frame_rot[47:32];
  assign fy = frame_rot[31:16];
  assign fz = frame_rot[15:0];

  assign pos_in[0] = sample.pos_x;
  assign pos_in[1] = sample.pos_y;
  assign pos_in[2] = sample.pos_z;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sprod[i] = 40'(pos_in[i]) * 40'(frame_scale);
    end
  end

  // stage 1: scale positions, rounding half up; frame quaternion products
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      s1[i] <= S_W'((sprod[i] + HALF_S) >>> POS_FRAC);
    end
    xx <= 32'(fx) * 32'(fx);
    yy <= 32'(fy) * 32'(fy);
    zz <= 32'(fz) * 32'(fz);
    xy <= 32'(fx) * 32'(fy);
    wz <= 32'(fw) * 32'(fz);
    xz <= 32'(fx) * 32'(fz);
    wy <= 32'(fw) * 32'(fy);
    yz <= 32'(fy) * 32'(fz);
    wx <= 32'(fw) * 32'(fx);
  end

  // stage 2: rotation matrix at Q.28 (unit-quaternion form, not normalized)
  always_ff @(posedge clk) begin
    m[0][0] <= ONE_M - ((M_W'(yy) + M_W'(zz)) <<< 1);
    m[0][1] <= (M_W'(xy) - M_W'(wz)) <<< 1;
    m[0][2] <= (M_W'(xz) + M_W'(wy)) <<< 1;
    m[1][0] <= (M_W'(xy) + M_W'(wz)) <<< 1;
    m[1][1] <= ONE_M - ((M_W'(xx) + M_W'(zz)) <<< 1);
    m[1][2] <= (M_W'(yz) - M_W'(wx)) <<< 1;
    m[2][0] <= (M_W'(xz) - M_W'(wy)) <<< 1;
    m[2][1] <= (M_W'(yz) + M_W'(wx)) <<< 1;
    m[2][2] <= ONE_M - ((M_W'(xx) + M_W'(yy)) <<< 1);
    for (int i = 0; i < 3; i++) begin
      s2[i] <= s1[i];
    end
  end

  // stage 3: nine matrix-vector products
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        mp[i][j] <= P_W'(m[i][j]) * P_W'(s2[j]);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc[i] = A_W'(mp[i][0]) + A_W'(mp[i][1]) + A_W'(mp[i][2]) + HALF_M;
    end
  end

  // stage 4: sum rows and round back to Q24.12
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      rnd4[i] <= R_W'(acc[i] >>> M_FRAC);
    end
  end

  // stage 5: translate and saturate; stage 6: hold to meet orientation
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      pos5[i] <= sat_pos(37'(rnd4[i]) + 37'(off[i]));
      pos6[i] <= pos5[i];
    end
  end

  // orientation: frame * ori * conj(frame) * local, left to right
  assign fq = frame_rot;
  assign lq = local_rot;
  assign oq = {sample.ori_w, sample.ori_x, sample.ori_y, sample.ori_z};
  // conjugate held at 17 bits so that -(-2.0) stays exact
  assign cq[3] = 17'(fw);
  assign cq[2] = -17'(fx);
  assign cq[1] = -17'(fy);
  assign cq[0] = -17'(fz);

  // packed index 3 is w; the multiplier indexes w at 0, so reverse here
  logic [3:0][QC_W-1:0] fq_r, lq_r, oq_r;
  logic [3:0][16:0]     cq_r;
  logic [3:0][19:0]     t1_r;
  logic [3:0][22:0]     t2_r;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      fq_r[k] = fq[3-k];
      lq_r[k] = lq[3-k];
      oq_r[k] = oq[3-k];
      cq_r[k] = cq[3-k];
      t1_r[k] = t1[k];
      t2_r[k] = t2[k];
    end
  end

  sptf_quat_mul #(.AW(QC_W), .BW(QC_W), .RW(20)) u_q1 (
    .clk(clk), .rst(rst), .in_vld(accept), .a(fq_r), .b(oq_r),
    .out_vld(q1_vld), .r(t1)
  );

  sptf_quat_mul #(.AW(20), .BW(17), .RW(23)) u_q2 (
    .clk(clk), .rst(rst), .in_vld(q1_vld), .a(t1_r), .b(cq_r),
    .out_vld(q2_vld), .r(t2)
  );

  sptf_quat_mul #(.AW(23), .BW(QC_W), .RW(26)) u_q3 (
    .clk(clk), .rst(rst), .in_vld(q2_vld), .a(t2_r), .b(lq_r),
    .out_vld(q3_vld), .r(t3)
  );

  assign done = v6;

  always_comb begin
    result.world_x     = pos6[0];
    result.world_y     = pos6[1];
    result.world_z     = pos6[2];
    result.world_ori_w = sat_ori($signed(t3[0]));
    result.world_ori_x = sat_ori($signed(t3[1]));
    result.world_ori_y = sat_ori($signed(t3[2]));
    result.world_ori_z = sat_ori($signed(t3[3]));
  end

`ifndef SYNTHESIS
  // every result traces back to an earlier accepted transaction
  a_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, 6))
    else $error("result without a matching accepted transaction");

  // position and orientation pipelines stay in step
  a_aligned: assert property (@(posedge clk) disable iff (rst)
    v6 == q3_vld)
    else $error("position and orientation paths out of step");

  // a transaction accepted now is later delivered on done
  a_deliver: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##6 done)
    else $error("accepted transaction not delivered");
`endif

endmodule
